/* hdl/ccw_pkg.sv */
// Shared types, constants and lookup functions for the calendar clock core.
// Depends on nothing; every other file of the block but ccw_if.sv refers to it by scoped names.
`default_nettype none

package ccw_pkg;

   // Command codes carried in the func field of a request.
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SET_TIME = 2'd1,
      OP_SET_DATE = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   // Time-of-day limits.
   localparam logic [9:0] MS_LAST    = 10'd999;
   localparam logic [5:0] SEC_LAST   = 6'd59;
   localparam logic [5:0] MIN_LAST   = 6'd59;
   localparam logic [4:0] HOUR_LAST  = 5'd23;
   localparam logic [4:0] HOUR_COUNT = 5'd24;
   localparam logic [5:0] MIN_COUNT  = 6'd60;

   // Calendar limits.
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [3:0]  MONTH_MARCH = 4'd3;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [13:0] YEAR_LAST   = 14'd16383;
   localparam logic [13:0] YEAR_MIN    = 14'd2000;
   localparam logic [13:0] YEAR_MAX    = 14'd2099;
   localparam logic [6:0]  YMOD100_LAST = 7'd99;
   localparam logic [8:0]  YMOD400_LAST = 9'd399;

   // Century of every settable year, and the four centuries added before Zeller.
   localparam logic [7:0] CENT_SET    = 8'd20;
   localparam logic [7:0] CENT_OFFSET = 8'd4;

   // State after reset: 12:00:00.000 on 7 May 2026.
   localparam logic [4:0]  RST_HOUR    = 5'd12;
   localparam logic [13:0] RST_YEAR    = 14'd2026;
   localparam logic [3:0]  RST_MONTH   = 4'd5;
   localparam logic [4:0]  RST_DAY     = 5'd7;
   localparam logic [6:0]  RST_YMOD100 = 7'd26;
   localparam logic [8:0]  RST_YMOD400 = 9'd26;
   localparam logic [7:0]  RST_CENT    = 8'd20;

   // A classified request as it sits in the queue.
   typedef struct packed {
      op_type      op;
      logic        reject;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } cmd_type;

   // Clock and calendar after one request, with the year split for the weekday.
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        status;
      logic [6:0]  ymod100;
      logic [7:0]  century;
   } snap_type;

   // Days in a month; codes outside 1..12 count as 31 days.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         4'd2:                   days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
         default:                days = 5'd31;
      endcase
      return days;
   endfunction

   // Zeller month term floor(13 * (m + 1) / 5), with January and February
   // counted as months 13 and 14 of the year before.
   function automatic logic [5:0] zeller_month_term(input logic [3:0] month);
      logic [5:0] term;
      case (month)
         4'd0:    term = 6'd33;
         4'd1:    term = 6'd36;
         4'd2:    term = 6'd39;
         4'd3:    term = 6'd10;
         4'd4:    term = 6'd13;
         4'd5:    term = 6'd15;
         4'd6:    term = 6'd18;
         4'd7:    term = 6'd20;
         4'd8:    term = 6'd23;
         4'd9:    term = 6'd26;
         4'd10:   term = 6'd28;
         4'd11:   term = 6'd31;
         4'd12:   term = 6'd33;
         4'd13:   term = 6'd36;
         4'd14:   term = 6'd39;
         default: term = 6'd41;
      endcase
      return term;
   endfunction

endpackage

`default_nettype wire

/* hdl/ccw_if.sv */
// Valid/ready channel interfaces for requests and responses of the calendar clock core.
// Stand-alone; field widths follow the request and response formats.
`default_nettype none

interface ccw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  in_hour;
   logic [5:0]  in_minute;
   logic [5:0]  in_second;
   logic [13:0] in_year;
   logic [3:0]  in_month;
   logic [4:0]  in_day;

   modport source (output valid, func, in_hour, in_minute, in_second, in_year, in_month,
                   in_day, input ready);
   modport sink (input valid, func, in_hour, in_minute, in_second, in_year, in_month,
                 in_day, output ready);
endinterface

interface ccw_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  out_hour;
   logic [5:0]  out_minute;
   logic [5:0]  out_second;
   logic [13:0] out_year;
   logic [3:0]  out_month;
   logic [4:0]  out_day;
   logic [2:0]  weekday;
   logic        status;

   modport source (output valid, out_hour, out_minute, out_second, out_year, out_month,
                   out_day, weekday, status, input ready);
   modport sink (input valid, out_hour, out_minute, out_second, out_year, out_month,
                 out_day, weekday, status, output ready);
endinterface

`default_nettype wire

/* hdl/ccw_front.sv */
// Front end: takes requests, decodes the command and checks set values for range.
// Uses ccw_pkg and the request interface from ccw_if.sv.
`default_nettype none

module ccw_front (
   ccw_req_if.sink         req_ch,
   input  wire logic       push_ready,
   output logic            push_valid,
   output ccw_pkg::cmd_type push_cmd
);

   ccw_pkg::op_type op;
   logic            bad_time;
   logic            bad_date;

   assign op = ccw_pkg::op_type'(req_ch.func);

   // Range checks for the two set commands; the day is not checked against the month.
   assign bad_time = (req_ch.in_hour >= ccw_pkg::HOUR_COUNT)
                  || (req_ch.in_minute >= ccw_pkg::MIN_COUNT)
                  || (req_ch.in_second >= ccw_pkg::MIN_COUNT);
   assign bad_date = (req_ch.in_year < ccw_pkg::YEAR_MIN)
                  || (req_ch.in_year > ccw_pkg::YEAR_MAX)
                  || (req_ch.in_month < ccw_pkg::MONTH_FIRST)
                  || (req_ch.in_month > ccw_pkg::MONTH_LAST)
                  || (req_ch.in_day < ccw_pkg::DAY_FIRST);

   // Classify the request and hand it to the queue.
   always_comb begin
      push_cmd.op     = op;
      push_cmd.hour   = req_ch.in_hour;
      push_cmd.minute = req_ch.in_minute;
      push_cmd.second = req_ch.in_second;
      push_cmd.year   = req_ch.in_year;
      push_cmd.month  = req_ch.in_month;
      push_cmd.day    = req_ch.in_day;
      unique case (op)
         ccw_pkg::OP_SET_TIME: push_cmd.reject = bad_time;
         ccw_pkg::OP_SET_DATE: push_cmd.reject = bad_date;
         default:              push_cmd.reject = 1'b0;
      endcase
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

`default_nettype wire

/* hdl/ccw_queue.sv */
// Short request queue between the front end and the execute stage.
// Uses ccw_pkg for the entry type.
`default_nettype none

module ccw_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire ccw_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output ccw_pkg::cmd_type      pop_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   ccw_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/ccw_exec.sv */
// Execute stage: holds the clock and calendar state and applies one request per cycle while the
// weekday stage accepts its snapshots. Uses ccw_pkg for command, snapshot types and month lengths.
`default_nettype none

module ccw_exec (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire ccw_pkg::cmd_type cmd,
   output logic                  snap_valid,
   input  wire logic             snap_ready,
   output ccw_pkg::snap_type     snap
);

   logic [9:0]  ms_ff, ms_in;
   logic [5:0]  second_ff, second_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  hour_ff, hour_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [6:0]  ymod100_ff, ymod100_in;
   logic [8:0]  ymod400_ff, ymod400_in;
   logic [7:0]  cent_ff, cent_in;
   logic        snap_valid_ff, snap_valid_in;
   ccw_pkg::snap_type snap_ff, snap_in;

   logic        take;
   logic        day_roll;
   logic        leap;
   logic [5:0]  day_next;
   logic        status;

   assign cmd_ready = !snap_valid_ff || snap_ready;
   assign take      = cmd_valid && cmd_ready;

   // Leap year from the year's remainders, which are tracked alongside the year.
   assign leap     = ((ymod100_ff != '0) && (year_ff[1:0] == 2'b00)) || (ymod400_ff == '0);
   assign day_next = {1'b0, day_ff} + 6'd1;

   // Next state for the request at the head of the queue.
   always_comb begin
      ms_in      = ms_ff;
      second_in  = second_ff;
      minute_in  = minute_ff;
      hour_in    = hour_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      ymod100_in = ymod100_ff;
      ymod400_in = ymod400_ff;
      cent_in    = cent_ff;
      day_roll   = 1'b0;
      status     = 1'b0;

      unique case (cmd.op)
         ccw_pkg::OP_TICK: begin
            // Millisecond tick with carries through seconds, minutes and hours.
            if (ms_ff == ccw_pkg::MS_LAST) begin
               ms_in = '0;
               if (second_ff == ccw_pkg::SEC_LAST) begin
                  second_in = '0;
                  if (minute_ff == ccw_pkg::MIN_LAST) begin
                     minute_in = '0;
                     if (hour_ff == ccw_pkg::HOUR_LAST) begin
                        hour_in  = '0;
                        day_roll = 1'b1;
                     end else begin
                        hour_in = hour_ff + 5'd1;
                     end
                  end else begin
                     minute_in = minute_ff + 6'd1;
                  end
               end else begin
                  second_in = second_ff + 6'd1;
               end
            end else begin
               ms_in = ms_ff + 10'd1;
            end
         end
         ccw_pkg::OP_SET_TIME: begin
            if (cmd.reject) begin
               status = 1'b1;
            end else begin
               hour_in   = cmd.hour;
               minute_in = cmd.minute;
               second_in = cmd.second;
               ms_in     = '0;
            end
         end
         ccw_pkg::OP_SET_DATE: begin
            // Every settable year lies in the century starting at 2000.
            if (cmd.reject) begin
               status = 1'b1;
            end else begin
               year_in    = cmd.year;
               month_in   = cmd.month;
               day_in     = cmd.day;
               ymod100_in = 7'(cmd.year - ccw_pkg::YEAR_MIN);
               ymod400_in = 9'(cmd.year - ccw_pkg::YEAR_MIN);
               cent_in    = ccw_pkg::CENT_SET;
            end
         end
         ccw_pkg::OP_READ: begin
            status = 1'b0;
         end
         default: begin
            status = 1'b0;
         end
      endcase

      // Date advance at midnight. A day past the month length starts the next month.
      if (day_roll) begin
         if (day_next > {1'b0, ccw_pkg::month_days(month_ff, leap)}) begin
            day_in = ccw_pkg::DAY_FIRST;
            if (month_ff >= ccw_pkg::MONTH_LAST) begin
               month_in = ccw_pkg::MONTH_FIRST;
               if (year_ff == ccw_pkg::YEAR_LAST) begin
                  year_in    = '0;
                  ymod100_in = '0;
                  ymod400_in = '0;
                  cent_in    = '0;
               end else begin
                  year_in    = year_ff + 14'd1;
                  ymod400_in = (ymod400_ff == ccw_pkg::YMOD400_LAST) ? '0 : ymod400_ff + 9'd1;
                  if (ymod100_ff == ccw_pkg::YMOD100_LAST) begin
                     ymod100_in = '0;
                     cent_in    = cent_ff + 8'd1;
                  end else begin
                     ymod100_in = ymod100_ff + 7'd1;
                  end
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            day_in = day_next[4:0];
         end
      end
   end

   // Snapshot of the state after the request, passed to the weekday stage.
   always_comb begin
      snap_in.hour    = hour_in;
      snap_in.minute  = minute_in;
      snap_in.second  = second_in;
      snap_in.year    = year_in;
      snap_in.month   = month_in;
      snap_in.day     = day_in;
      snap_in.status  = status;
      snap_in.ymod100 = ymod100_in;
      snap_in.century = cent_in;
      snap_valid_in   = cmd_ready ? take : snap_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff         <= '0;
         second_ff     <= '0;
         minute_ff     <= '0;
         hour_ff       <= ccw_pkg::RST_HOUR;
         year_ff       <= ccw_pkg::RST_YEAR;
         month_ff      <= ccw_pkg::RST_MONTH;
         day_ff        <= ccw_pkg::RST_DAY;
         ymod100_ff    <= ccw_pkg::RST_YMOD100;
         ymod400_ff    <= ccw_pkg::RST_YMOD400;
         cent_ff       <= ccw_pkg::RST_CENT;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (take) begin
            ms_ff      <= ms_in;
            second_ff  <= second_in;
            minute_ff  <= minute_in;
            hour_ff    <= hour_in;
            year_ff    <= year_in;
            month_ff   <= month_in;
            day_ff     <= day_in;
            ymod100_ff <= ymod100_in;
            ymod400_ff <= ymod400_in;
            cent_ff    <= cent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

`default_nettype wire

/* hdl/ccw_wday.sv */
// Weekday pipeline and response register: Zeller sum, then the sum modulo 7.
// Uses ccw_pkg for the snapshot type and the month term table, and ccw_rsp_if.
`default_nettype none

module ccw_wday (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              snap_valid,
   output logic                   snap_ready,
   input  wire ccw_pkg::snap_type snap,
   ccw_rsp_if.source              rsp_ch
);

   logic              sum_valid_ff, sum_valid_in;
   ccw_pkg::snap_type sum_snap_ff;
   logic [10:0]       sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ccw_pkg::snap_type rsp_snap_ff;
   logic [2:0]        rsp_wday_ff, rsp_wday_in;

   logic              sum_ready;
   logic              rsp_free;
   logic              early;
   logic              borrow;
   logic [6:0]        yr_k;
   logic [7:0]        yr_j;
   logic [4:0]        fold1;
   logic [3:0]        fold2;
   logic [2:0]        zel_h;

   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign sum_ready  = !sum_valid_ff || rsp_free;
   assign snap_ready = sum_ready;

   // Zeller terms on the year plus 400; January and February belong to the year before.
   assign early  = (snap.month < ccw_pkg::MONTH_MARCH);
   assign borrow = early && (snap.ymod100 == '0);
   assign yr_k   = !early ? snap.ymod100
                 : (borrow ? ccw_pkg::YMOD100_LAST : snap.ymod100 - 7'd1);
   assign yr_j   = snap.century + ccw_pkg::CENT_OFFSET - {7'd0, borrow};
   assign sum_in = 11'(snap.day) + 11'(ccw_pkg::zeller_month_term(snap.month))
                 + 11'(yr_k) + 11'(yr_k[6:2]) + 11'(yr_j[7:2])
                 + {1'b0, yr_j, 2'b00} + 11'(yr_j);

   // Sum modulo 7 by folding octal digits, since 8 is 1 modulo 7.
   assign fold1 = 5'(sum_ff[2:0]) + 5'(sum_ff[5:3]) + 5'(sum_ff[8:6]) + 5'(sum_ff[10:9]);
   assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
   assign zel_h = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

   // Zeller counts from Saturday; the response counts from Sunday.
   assign rsp_wday_in  = (zel_h == 3'd0) ? 3'd6 : zel_h - 3'd1;
   assign sum_valid_in = sum_ready ? snap_valid : sum_valid_ff;
   assign rsp_valid_in = rsp_free ? sum_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && snap_valid) begin
         sum_snap_ff <= snap;
         sum_ff      <= sum_in;
      end
      if (rsp_free && sum_valid_ff) begin
         rsp_snap_ff <= sum_snap_ff;
         rsp_wday_ff <= rsp_wday_in;
      end
   end

   // Response channel.
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_hour   = rsp_snap_ff.hour;
   assign rsp_ch.out_minute = rsp_snap_ff.minute;
   assign rsp_ch.out_second = rsp_snap_ff.second;
   assign rsp_ch.out_year   = rsp_snap_ff.year;
   assign rsp_ch.out_month  = rsp_snap_ff.month;
   assign rsp_ch.out_day    = rsp_snap_ff.day;
   assign rsp_ch.weekday    = rsp_wday_ff;
   assign rsp_ch.status     = rsp_snap_ff.status;

endmodule

`default_nettype wire

/* hdl/calendar_clock_with_weekday_core.sv */
// Calendar clock with weekday. Each request is a millisecond tick, a set time, a set date
// or a read, and each produces exactly one response with the time, date, weekday (0 is
// Sunday) and a status that is 1 when a set value is out of range. The core sustains one
// request per clock cycle while the response side accepts responses: the execute stage
// computes the whole next clock and calendar state combinationally, carrying the year's
// remainders by 100 and 400 and its century so that neither the leap rule nor the weekday
// needs a divider. A request passes through the queue, the execute register, the weekday
// sum register and the response register in that order. Up to QUEUE_DEPTH requests wait
// in the queue when the response side stalls. After reset the clock reads 12:00:00 on
// 7 May 2026; no clearing pass is needed.
`default_nettype none

module calendar_clock_with_weekday_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   ccw_req_if.sink   req_ch,
   ccw_rsp_if.source rsp_ch
);

   logic              push_valid;
   logic              push_ready;
   ccw_pkg::cmd_type  push_cmd;
   logic              head_valid;
   logic              head_ready;
   ccw_pkg::cmd_type  head_cmd;
   logic              snap_valid;
   logic              snap_ready;
   ccw_pkg::snap_type snap;

   // Request decode and range checks.
   ccw_front u_front (
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Queue between front end and execute stage.
   ccw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_cmd    (head_cmd)
   );

   // Clock and calendar state update.
   ccw_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd_ready  (head_ready),
      .cmd        (head_cmd),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Weekday computation and response register.
   ccw_wday u_wday (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_ch     (rsp_ch)
   );

   // The weekday mapping never yields a code past Saturday.
   a_weekday_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.weekday <= 3'd6))
      else $error("weekday out of range");

   // The time-of-day counters stay within a day.
   a_time_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.out_hour < ccw_pkg::HOUR_COUNT)
                     && (rsp_ch.out_minute < ccw_pkg::MIN_COUNT)
                     && (rsp_ch.out_second < ccw_pkg::MIN_COUNT)))
      else $error("time of day out of range");

   // Month stays in 1..12 and the day stays at least 1 through rollovers and set dates.
   a_date_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.out_month >= ccw_pkg::MONTH_FIRST)
                     && (rsp_ch.out_month <= ccw_pkg::MONTH_LAST)
                     && (rsp_ch.out_day >= ccw_pkg::DAY_FIRST)))
      else $error("date out of range");

   // A stalled execute stage holds its request at the head of the queue.
   a_head_hold : assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head_ready) |=> (head_valid && $stable(head_cmd)))
      else $error("queue head lost while stalled");

endmodule

`default_nettype wire

/* bench/tb_calendar_clock_with_weekday_core.sv */
// Testbench for the calendar clock core: directed limits, a midnight and year-end rollover,
// and random request traffic, each response checked against an in-bench calendar model.
// Depends on ccw_pkg, on the ccw_req_if and ccw_rsp_if interfaces and on the core itself.
`default_nettype none

module tb_calendar_clock_with_weekday_core;

   // One expected response: time, date, weekday and status.
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      logic        status;
   } clock_reading_type;

   logic clock;
   logic reset;
   logic idle_on;
   int   mismatch_count;
   int   sent_total;

   // Model of the clock and calendar state.
   logic [9:0]  ms_count;
   logic [16:0] day_secs;
   logic [13:0] cal_year;
   logic [3:0]  cal_month;
   logic [4:0]  cal_day;

   clock_reading_type expected_readings[$];

   ccw_req_if req_ch();
   ccw_rsp_if rsp_ch();

   calendar_clock_with_weekday_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety limit on the whole run.
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Prints one mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Applies one request to the model state and returns the reading that follows it.
   function automatic clock_reading_type advance_clock(input ccw_pkg::op_type op,
                                                       input logic [4:0] hh,
                                                       input logic [5:0] mm,
                                                       input logic [5:0] ss,
                                                       input logic [13:0] yy,
                                                       input logic [3:0] mo,
                                                       input logic [4:0] dd);
      clock_reading_type r;
      logic [5:0] next_day;
      int month_len;
      bit leap;
      int zy, zm, k, j, h;
      r.status = 1'b0;
      case (op)
         ccw_pkg::OP_TICK: begin
            if (ms_count == 10'd999) begin
               ms_count = 10'd0;
               if (day_secs == 17'd86399) begin
                  // Midnight: step the date, the incremented day is one bit wider.
                  day_secs = 17'd0;
                  leap = ((cal_year % 4 == 0) && (cal_year % 100 != 0)) || (cal_year % 400 == 0);
                  case (cal_month) inside
                     4'd2:                    month_len = leap ? 29 : 28;
                     4'd4, 4'd6, 4'd9, 4'd11: month_len = 30;
                     default:                 month_len = 31;
                  endcase
                  next_day = {1'b0, cal_day} + 6'd1;
                  if (next_day > month_len) begin
                     next_day = 6'd1;
                     if (cal_month >= 4'd12) begin
                        cal_month = 4'd1;
                        cal_year = cal_year + 14'd1;
                     end else begin
                        cal_month = cal_month + 4'd1;
                     end
                  end
                  cal_day = next_day[4:0];
               end else begin
                  day_secs = day_secs + 17'd1;
               end
            end else begin
               ms_count = ms_count + 10'd1;
            end
         end
         ccw_pkg::OP_SET_TIME: begin
            if (hh < 24 && mm < 60 && ss < 60) begin
               day_secs = 17'(hh * 3600 + mm * 60 + ss);
               ms_count = 10'd0;
            end else begin
               r.status = 1'b1;
            end
         end
         ccw_pkg::OP_SET_DATE: begin
            if (yy >= 2000 && yy <= 2099 && mo >= 1 && mo <= 12 && dd >= 1) begin
               cal_year = yy;
               cal_month = mo;
               cal_day = dd;
            end else begin
               r.status = 1'b1;
            end
         end
         default: ;
      endcase
      r.hour = 5'(day_secs / 3600);
      r.minute = 6'((day_secs % 3600) / 60);
      r.second = 6'(day_secs % 60);
      r.year = cal_year;
      r.month = cal_month;
      r.day = cal_day;
      // Zeller's congruence, shifted by four centuries so every term stays positive.
      zy = int'(cal_year) + 400;
      zm = int'(cal_month);
      if (zm < 3) begin
         zm += 12;
         zy -= 1;
      end
      k = zy % 100;
      j = zy / 100;
      h = (int'(cal_day) + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      r.weekday = 3'((h + 6) % 7);
      return r;
   endfunction

   // Picks the idle gap before a request.
   function automatic int pick_gap();
      if (idle_on && $urandom_range(0, 7) == 0)
         return $urandom_range(1, 10);
      return 0;
   endfunction

   // Sends one request, waits for the handshake and records the expected response.
   task automatic send_request(input ccw_pkg::op_type op, input logic [4:0] hh,
                               input logic [5:0] mm, input logic [5:0] ss,
                               input logic [13:0] yy, input logic [3:0] mo,
                               input logic [4:0] dd);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= op;
      req_ch.in_hour   <= hh;
      req_ch.in_minute <= mm;
      req_ch.in_second <= ss;
      req_ch.in_year   <= yy;
      req_ch.in_month  <= mo;
      req_ch.in_day    <= dd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_readings.push_back(advance_clock(op, hh, mm, ss, yy, mo, dd));
      sent_total++;
   endtask

   // Sends a request whose value fields are all random.
   task automatic send_random_fields(input ccw_pkg::op_type op);
      send_request(op, 5'($urandom), 6'($urandom), 6'($urandom), 14'($urandom),
                   4'($urandom), 5'($urandom));
   endtask

   // Holds the sender until every outstanding response has come back.
   task automatic wait_for_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   // Sets a date and a time, then ticks one full second and one millisecond past it and reads.
   task automatic run_one_second(input logic [4:0] hh, input logic [5:0] mm,
                                 input logic [5:0] ss, input logic [13:0] yy,
                                 input logic [3:0] mo, input logic [4:0] dd);
      send_request(ccw_pkg::OP_SET_DATE, 5'($urandom), 6'($urandom), 6'($urandom),
                   yy, mo, dd);
      send_request(ccw_pkg::OP_SET_TIME, hh, mm, ss, 14'($urandom), 4'($urandom),
                   5'($urandom));
      repeat (1001) send_random_fields(ccw_pkg::OP_TICK);
      send_random_fields(ccw_pkg::OP_READ);
   endtask

   // State after reset, and a tick with every field at its extremes.
   task automatic test_reset_state();
      send_request(ccw_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
      send_request(ccw_pkg::OP_TICK, '1, '1, '1, '1, '1, '1);
      send_request(ccw_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
      send_request(ccw_pkg::OP_READ, '1, '1, '1, '1, '1, '1);
   endtask

   // Set time at its limits, valid and rejected.
   task automatic test_set_time_limits();
      send_request(ccw_pkg::OP_SET_TIME, 5'd0, 6'd0, 6'd0, '1, '1, '1);
      send_request(ccw_pkg::OP_SET_TIME, 5'd23, 6'd59, 6'd59, '0, '0, '0);
      send_request(ccw_pkg::OP_SET_TIME, 5'd24, 6'd0, 6'd0, '0, '0, '0);
      send_request(ccw_pkg::OP_SET_TIME, 5'd0, 6'd60, 6'd0, '0, '0, '0);
      send_request(ccw_pkg::OP_SET_TIME, 5'd0, 6'd0, 6'd60, '0, '0, '0);
      send_request(ccw_pkg::OP_SET_TIME, '1, '1, '1, '1, '1, '1);
   endtask

   // Set date at its limits, including a day beyond the end of its month.
   task automatic test_set_date_limits();
      send_request(ccw_pkg::OP_SET_DATE, '1, '1, '1, 14'd2000, 4'd1, 5'd1);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2099, 4'd12, 5'd31);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd1999, 4'd6, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2100, 4'd6, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2050, 4'd0, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2050, 4'd13, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2050, 4'd15, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2050, 4'd6, 5'd0);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd16383, 4'd6, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd0, 4'd6, 5'd15);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2024, 4'd2, 5'd29);
      send_request(ccw_pkg::OP_SET_DATE, '0, '0, '0, 14'd2024, 4'd2, 5'd31);
      send_request(ccw_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
      wait_for_responses();
   endtask

   // Second, minute, hour and midnight carries across the end of the last settable year,
   // which also moves the century and lands on January of the next year.
   task automatic test_rollovers();
      run_one_second(5'd23, 6'd59, 6'd59, 14'd2099, 4'd12, 5'd31);
      wait_for_responses();
   endtask

   // Mostly well-formed set and tick sequences with random content, some pure noise.
   task automatic test_random_traffic();
      int burst;
      while (sent_total < 1150) begin
         if (sent_total >= 1100)
            idle_on = 1'b0;
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 1) begin
               send_request(ccw_pkg::OP_SET_TIME, 5'($urandom_range(0, 23)),
                            ($urandom_range(0, 1) == 1) ? 6'd59 : 6'($urandom_range(0, 59)),
                            ($urandom_range(0, 1) == 1) ? 6'd59 : 6'($urandom_range(0, 59)),
                            14'($urandom), 4'($urandom), 5'($urandom));
            end
            if ($urandom_range(0, 2) == 0) begin
               send_request(ccw_pkg::OP_SET_DATE, 5'($urandom), 6'($urandom), 6'($urandom),
                            14'($urandom_range(2000, 2099)), 4'($urandom_range(1, 12)),
                            ($urandom_range(0, 1) == 1) ? 5'($urandom_range(28, 31))
                                                        : 5'($urandom_range(1, 31)));
            end
            burst = $urandom_range(1, 30);
            repeat (burst) send_random_fields(ccw_pkg::OP_TICK);
            send_random_fields(ccw_pkg::OP_READ);
         end else begin
            repeat (5) send_random_fields(ccw_pkg::op_type'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 19) == 0)
            wait_for_responses();
      end
   endtask

   // Response ready with random stall bursts.
   initial begin : rsp_ready_driver
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall = $urandom_range(1, 10);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Checks each accepted response against the oldest expected reading.
   always @(posedge clock) begin : response_check
      clock_reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("response with no request outstanding", 1, 0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_ch.out_hour !== want.hour)
               report_mismatch("out_hour", rsp_ch.out_hour, want.hour);
            if (rsp_ch.out_minute !== want.minute)
               report_mismatch("out_minute", rsp_ch.out_minute, want.minute);
            if (rsp_ch.out_second !== want.second)
               report_mismatch("out_second", rsp_ch.out_second, want.second);
            if (rsp_ch.out_year !== want.year)
               report_mismatch("out_year", rsp_ch.out_year, want.year);
            if (rsp_ch.out_month !== want.month)
               report_mismatch("out_month", rsp_ch.out_month, want.month);
            if (rsp_ch.out_day !== want.day)
               report_mismatch("out_day", rsp_ch.out_day, want.day);
            if (rsp_ch.weekday !== want.weekday)
               report_mismatch("weekday", rsp_ch.weekday, want.weekday);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   // Reset, the test sequence and the final verdict.
   initial begin
      mismatch_count = 0;
      sent_total = 0;
      idle_on = 1'b1;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = ccw_pkg::OP_READ;
      req_ch.in_hour = '0;
      req_ch.in_minute = '0;
      req_ch.in_second = '0;
      req_ch.in_year = '0;
      req_ch.in_month = '0;
      req_ch.in_day = '0;
      ms_count = 10'd0;
      day_secs = 17'd43200;
      cal_year = 14'd2026;
      cal_month = 4'd5;
      cal_day = 5'd7;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_set_time_limits();
      test_set_date_limits();
      test_rollovers();
      test_random_traffic();

      // Drain, then wait for any stray response before the verdict.
      wait_for_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
